// ===== sv/rvpid_pkg.sv =====
// Shared constants and types of the three-axis replay velocity PID unit.
package rvpid_pkg;

    localparam int GAIN_FRAC_BITS_DEF = 8;

    localparam int AXES = 3;
    localparam int AX_W = 2;
    localparam logic [AX_W-1:0] AX_LEFT  = 2'd0;
    localparam logic [AX_W-1:0] AX_RIGHT = 2'd1;
    localparam logic [AX_W-1:0] AX_LIFT  = 2'd2;

    localparam int CFG_AW = 4;
    localparam logic [1:0] REG_GAIN_P = 2'd0;
    localparam logic [1:0] REG_GAIN_I = 2'd1;
    localparam logic [1:0] REG_GAIN_D = 2'd2;
    localparam logic [1:0] REG_ILIMIT = 2'd3;

    localparam logic signed [15:0] GAIN_P_RST = 16'sd256;
    localparam logic signed [15:0] GAIN_I_RST = 16'sd0;
    localparam logic signed [15:0] GAIN_D_RST = 16'sd0;
    localparam logic [30:0]        ILIMIT_RST = 31'd1000;

    // Result queue; also bounds the items in flight.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    localparam int PROD_W = 48;
    localparam int SUM_W  = 50;

    // One axis worth of loop state.
    typedef struct packed {
        logic signed [31:0] integ;
        logic signed [31:0] lerr;
        logic        [31:0] lmeas;
        logic        [31:0] lrec;
    } t_entry;

    typedef struct packed {
        logic       stop;
        logic [7:0] left;
        logic [7:0] right;
        logic [7:0] lift;
    } t_result;

endpackage

// ===== sv/replay_velocity_pid_three_axis_unit.sv =====
// Three-axis replay velocity PID corrector: top level.
// A new item is accepted no sooner than the previous item's last axis issues; the three axes
// share one state memory port and one PID datapath, one axis issued per cycle.
// Up to 4 items in flight, bounded by the result queue.
// Synchronous reset clears loop state (via per-axis valid bits) and loads reset gains.
module replay_velocity_pid_three_axis_unit
    import rvpid_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_AW-1:0]        paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    // input channel
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [7:0]        i_left_rec_drive,
    input  logic signed [7:0]        i_right_rec_drive,
    input  logic signed [7:0]        i_lift_rec_drive,
    input  logic signed [31:0]       i_left_rec_pos,
    input  logic signed [31:0]       i_right_rec_pos,
    input  logic signed [31:0]       i_lift_rec_pos,
    input  logic signed [31:0]       i_left_meas_pos,
    input  logic signed [31:0]       i_right_meas_pos,
    input  logic signed [31:0]       i_lift_meas_pos,
    input  logic                     i_stop_request,
    // output channel
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [7:0]        o_left_drive,
    output logic signed [7:0]        o_right_drive,
    output logic signed [7:0]        o_lift_drive,
    output logic                     o_stop_all
);

    localparam logic [SUM_W-1:0] RND_MASK =
        (SUM_W'(1) << GAIN_FRAC_BITS) - SUM_W'(1);

    // ---------------- configuration ----------------
    logic signed [15:0] r_gain_p;
    logic signed [15:0] r_gain_i;
    logic signed [15:0] r_gain_d;
    logic        [30:0] r_ilimit;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p <= GAIN_P_RST;
            r_gain_i <= GAIN_I_RST;
            r_gain_d <= GAIN_D_RST;
            r_ilimit <= ILIMIT_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_GAIN_P: r_gain_p <= pwdata[15:0];
                REG_GAIN_I: r_gain_i <= pwdata[15:0];
                REG_GAIN_D: r_gain_d <= pwdata[15:0];
                REG_ILIMIT: r_ilimit <= pwdata[30:0];
                default:    r_gain_p <= r_gain_p;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_GAIN_P: prdata = {{16{r_gain_p[15]}}, r_gain_p};
            REG_GAIN_I: prdata = {{16{r_gain_i[15]}}, r_gain_i};
            REG_GAIN_D: prdata = {{16{r_gain_d[15]}}, r_gain_d};
            REG_ILIMIT: prdata = {1'b0, r_ilimit};
            default:    prdata = '0;
        endcase
    end

    // ---------------- input buffer and axis issue ----------------
    logic                r_buf_v;
    logic [AX_W-1:0]     r_ax;
    logic [7:0]          r_b_drv [AXES];
    logic [31:0]         r_b_rec [AXES];
    logic [31:0]         r_b_meas[AXES];
    logic                r_b_stop;
    logic [QCNT_W-1:0]   r_outst;
    logic                acc_in;
    logic                pop;
    logic                push;
    logic [QCNT_W-1:0]   n_outst;

    assign o_stall = !(((!r_buf_v) || (r_ax == AX_LIFT)) && (r_outst < QCNT_W'(QDEPTH)));
    assign acc_in  = i_valid && !o_stall;

    always_comb begin
        case ({acc_in, pop})
            2'b10:   n_outst = r_outst + QCNT_W'(1);
            2'b01:   n_outst = r_outst - QCNT_W'(1);
            default: n_outst = r_outst;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_v <= 1'b0;
            r_ax    <= AX_LEFT;
            r_outst <= '0;
        end else begin
            r_outst <= n_outst;
            if (acc_in) begin
                r_buf_v <= 1'b1;
                r_ax    <= AX_LEFT;
            end else if (r_buf_v) begin
                if (r_ax == AX_LIFT) begin
                    r_buf_v <= 1'b0;
                end else begin
                    r_ax <= r_ax + AX_W'(1);
                end
            end
        end
    end

    // right drive is negated on entry (wraps, so -128 stays -128)
    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_b_drv[0]  <= i_left_rec_drive;
            r_b_drv[1]  <= 8'd0 - i_right_rec_drive;
            r_b_drv[2]  <= i_lift_rec_drive;
            r_b_rec[0]  <= i_left_rec_pos;
            r_b_rec[1]  <= i_right_rec_pos;
            r_b_rec[2]  <= i_lift_rec_pos;
            r_b_meas[0] <= i_left_meas_pos;
            r_b_meas[1] <= i_right_meas_pos;
            r_b_meas[2] <= i_lift_meas_pos;
            r_b_stop    <= i_stop_request;
        end
    end

    // ---------------- state memory ----------------
    t_entry              r_mem [AXES];
    logic [AXES-1:0]     r_mem_ok;
    t_entry              r_rd;
    logic                r_rd_ok;
    t_entry              wb3;

    // pipeline registers
    logic                r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v, r_s6_v;
    logic [AX_W-1:0]     r_s1_ax, r_s2_ax, r_s3_ax, r_s4_ax, r_s5_ax, r_s6_ax;
    logic [7:0]          r_s1_drv, r_s2_drv, r_s3_drv, r_s4_drv, r_s5_drv, r_s6_drv;
    logic                r_s1_stop, r_s2_stop, r_s3_stop, r_s4_stop, r_s5_stop, r_s6_stop;
    logic [31:0]         r_s1_rec, r_s1_meas;
    logic signed [31:0]  r_s2_e, r_s2_integ, r_s2_lerr;
    logic [31:0]         r_s2_wm, r_s2_wr;
    logic signed [31:0]  r_s3_e, r_s3_d;
    logic signed [32:0]  r_s3_sum;
    logic                r_s3_mism;
    logic [31:0]         r_s3_wm, r_s3_wr;
    logic signed [31:0]  r_s4_e, r_s4_d, r_s4_acc;
    t_entry              r_s4_wb;
    logic signed [PROD_W-1:0] r_s5_pp, r_s5_pi, r_s5_pd;
    logic signed [SUM_W-1:0]  r_s6_s;

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_ax];
        if (r_s3_v) begin
            r_mem[r_s3_ax] <= wb3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_ok <= '0;
            r_rd_ok  <= 1'b0;
        end else begin
            r_rd_ok <= r_mem_ok[r_ax];
            if (r_s3_v) begin
                r_mem_ok[r_s3_ax] <= 1'b1;
            end
        end
    end

    // ---------------- stage 1: velocity error ----------------
    t_entry              ent1;
    logic [31:0]         e1;

    // same axis of the next item reads on the edge that writes it back
    always_comb begin
        if (r_s4_v && (r_s4_ax == r_s1_ax)) begin
            ent1 = r_s4_wb;
        end else if (r_rd_ok) begin
            ent1 = r_rd;
        end else begin
            ent1 = '0;
        end
        e1 = (r_s1_rec - ent1.lrec) - (r_s1_meas - ent1.lmeas);
    end

    // ---------------- stage 2: integral sum, derivative ----------------
    logic signed [32:0]  sum2;
    logic signed [31:0]  d2;
    logic                mism2;

    assign sum2  = 33'(r_s2_integ) + 33'(r_s2_e);
    assign d2    = r_s2_e - r_s2_lerr;
    assign mism2 = (r_s2_e[31] != r_s2_lerr[31]) || ((r_s2_e == '0) != (r_s2_lerr == '0));

    // ---------------- stage 3: clamp, zero on error sign change, write back ----------------
    logic signed [32:0]  lim3;
    logic signed [32:0]  nlim3;
    logic signed [32:0]  clamp3;
    logic signed [31:0]  acc3;

    always_comb begin
        lim3  = signed'({2'b00, r_ilimit});
        nlim3 = -lim3;
        if (r_s3_sum > lim3) begin
            clamp3 = lim3;
        end else if (r_s3_sum < nlim3) begin
            clamp3 = nlim3;
        end else begin
            clamp3 = r_s3_sum;
        end
        acc3      = r_s3_mism ? '0 : clamp3[31:0];
        wb3.integ = acc3;
        wb3.lerr  = r_s3_e;
        wb3.lmeas = r_s3_wm;
        wb3.lrec  = r_s3_wr;
    end

    // ---------------- stages 4..6: products, sum, rounding ----------------
    logic signed [PROD_W-1:0] mp4, mi4, md4;
    logic signed [SUM_W-1:0]  s5;
    logic [SUM_W-1:0]         sadj6;
    logic [7:0]               c6;
    logic [7:0]               drv6;

    assign mp4   = PROD_W'(r_gain_p) * PROD_W'(r_s4_e);
    assign mi4   = PROD_W'(r_gain_i) * PROD_W'(r_s4_acc);
    assign md4   = PROD_W'(r_gain_d) * PROD_W'(r_s4_d);
    assign s5    = SUM_W'(r_s5_pp) + SUM_W'(r_s5_pi) + SUM_W'(r_s5_pd);
    // truncation toward zero: bias negative sums before the shift
    assign sadj6 = r_s6_s + (r_s6_s[SUM_W-1] ? RND_MASK : '0);
    assign c6    = sadj6[GAIN_FRAC_BITS +: 8];
    assign drv6  = r_s6_drv + c6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
            r_s6_v <= 1'b0;
        end else begin
            r_s1_v <= r_buf_v;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_s5_v <= r_s4_v;
            r_s6_v <= r_s5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_ax    <= r_ax;
        r_s1_drv   <= r_b_drv[r_ax];
        r_s1_rec   <= r_b_rec[r_ax];
        r_s1_meas  <= r_b_meas[r_ax];
        r_s1_stop  <= r_b_stop;

        r_s2_ax    <= r_s1_ax;
        r_s2_drv   <= r_s1_drv;
        r_s2_stop  <= r_s1_stop;
        r_s2_e     <= e1;
        r_s2_integ <= ent1.integ;
        r_s2_lerr  <= ent1.lerr;
        r_s2_wm    <= r_s1_stop ? ent1.lmeas : r_s1_meas;
        r_s2_wr    <= r_s1_stop ? ent1.lrec  : r_s1_rec;

        r_s3_ax    <= r_s2_ax;
        r_s3_drv   <= r_s2_drv;
        r_s3_stop  <= r_s2_stop;
        r_s3_e     <= r_s2_e;
        r_s3_d     <= d2;
        r_s3_sum   <= sum2;
        r_s3_mism  <= mism2;
        r_s3_wm    <= r_s2_wm;
        r_s3_wr    <= r_s2_wr;

        r_s4_ax    <= r_s3_ax;
        r_s4_drv   <= r_s3_drv;
        r_s4_stop  <= r_s3_stop;
        r_s4_e     <= r_s3_e;
        r_s4_d     <= r_s3_d;
        r_s4_acc   <= acc3;
        r_s4_wb    <= wb3;

        r_s5_ax    <= r_s4_ax;
        r_s5_drv   <= r_s4_drv;
        r_s5_stop  <= r_s4_stop;
        r_s5_pp    <= mp4;
        r_s5_pi    <= mi4;
        r_s5_pd    <= md4;

        r_s6_ax    <= r_s5_ax;
        r_s6_drv   <= r_s5_drv;
        r_s6_stop  <= r_s5_stop;
        r_s6_s     <= s5;
    end

    // ---------------- result assembly and queue ----------------
    logic [7:0]          r_acc_l;
    logic [7:0]          r_acc_r;
    t_result             r_q [QDEPTH];
    logic [QPTR_W-1:0]   r_qhd;
    logic [QPTR_W-1:0]   r_qtl;
    logic [QCNT_W-1:0]   r_qcnt;
    t_result             n_res;
    t_result             q_head;

    assign push = r_s6_v && (r_s6_ax == AX_LIFT);
    assign pop  = o_valid && !i_stall;

    always_comb begin
        n_res.stop  = r_s6_stop;
        n_res.left  = r_s6_stop ? 8'd0 : r_acc_l;
        n_res.right = r_s6_stop ? 8'd0 : r_acc_r;
        n_res.lift  = r_s6_stop ? 8'd0 : drv6;
    end

    always_ff @(posedge i_clk) begin
        if (r_s6_v && (r_s6_ax == AX_LEFT)) begin
            r_acc_l <= drv6;
        end
        if (r_s6_v && (r_s6_ax == AX_RIGHT)) begin
            r_acc_r <= drv6;
        end
        if (push) begin
            r_q[r_qtl] <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qhd  <= '0;
            r_qtl  <= '0;
            r_qcnt <= '0;
        end else begin
            if (push) begin
                r_qtl <= r_qtl + QPTR_W'(1);
            end
            if (pop) begin
                r_qhd <= r_qhd + QPTR_W'(1);
            end
            case ({push, pop})
                2'b10:   r_qcnt <= r_qcnt + QCNT_W'(1);
                2'b01:   r_qcnt <= r_qcnt - QCNT_W'(1);
                default: r_qcnt <= r_qcnt;
            endcase
        end
    end

    assign q_head        = r_q[r_qhd];
    assign o_valid       = (r_qcnt != '0);
    assign o_left_drive  = q_head.left;
    assign o_right_drive = q_head.right;
    assign o_lift_drive  = q_head.lift;
    assign o_stop_all    = q_head.stop;

    // ---------------- assertions ----------------
    a_outst_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outst <= QCNT_W'(QDEPTH))
        else $error("items in flight exceed queue depth");

    a_queue_within_outst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qcnt <= r_outst)
        else $error("queued results exceed items in flight");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_qcnt < r_outst))
        else $error("result pushed with no item outstanding");

    a_axis_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_buf_v && (r_ax != AX_LIFT)) |=> (r_buf_v && (r_ax == $past(r_ax) + AX_W'(1))))
        else $error("axis issue sequence broken");

endmodule
